@@ src/bpdc_pkg.sv @@
// Package for the button press duration classifier.
// Holds the sizes, the beat payload types, the register indexes and the event codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bpdc_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int MASK_W      = 4;
	localparam int SCAN_COUNT  = (NUM_BUTTONS < MASK_W) ? NUM_BUTTONS : MASK_W;
	localparam int IDX_W       = (SCAN_COUNT > 1) ? $clog2(SCAN_COUNT) : 1;
	localparam int TICK_W      = 32;
	localparam int CFG_IDX_W   = 1;

	localparam logic [TICK_W-1:0] LONG_PRESS_RESET = 32'd1000;
	localparam logic [TICK_W-1:0] CONT_PRESS_RESET = 32'd3000;

	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONT_PRESS = 1'd1;

	localparam logic [1:0] EV_SHORT      = 2'd0;
	localparam logic [1:0] EV_LONG       = 2'd1;
	localparam logic [1:0] EV_AFTER_CONT = 2'd2;
	localparam logic [1:0] EV_CONTINUOUS = 2'd3;

	typedef struct packed {
		logic [TICK_W-1:0] now_tick;
		logic [MASK_W-1:0] clicked_mask;
		logic [MASK_W-1:0] level_mask;
	} in_t;

	typedef struct packed {
		logic       is_status;
		logic [1:0] button_index;
		logic [1:0] event_kind;
		logic       recheck_short;
		logic       recheck_repeat;
		logic       go_idle;
		logic       last;
	} out_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit_status;
	} cmd_t;

	typedef struct packed {
		logic last_btn;
		logic slot_free;
	} stat_t;

endpackage
`default_nettype wire

@@ src/bpdc_ctrl.sv @@
// Controller for the button press duration classifier.
// Sequences load, one step per button and the closing status beat.
// Depends on bpdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bpdc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire bpdc_pkg::stat_t stat,
	output bpdc_pkg::cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_STAT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d          = state_q;
		cmd.load         = 1'b0;
		cmd.step         = 1'b0;
		cmd.emit_status  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.slot_free) begin
					cmd.step = 1'b1;
					if (stat.last_btn)
						state_d = ST_STAT;
				end
			end
			ST_STAT: begin
				if (stat.slot_free) begin
					cmd.emit_status = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule
`default_nettype wire

@@ src/bpdc_dp.sv @@
// Datapath for the button press duration classifier.
// Holds the registers, press tracking, duration compare and the output beat register.
// Depends on bpdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bpdc_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [bpdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bpdc_pkg::TICK_W-1:0]    cfg_wdata,
	input  wire bpdc_pkg::in_t                  in_data,
	input  wire bpdc_pkg::cmd_t                 cmd,
	output bpdc_pkg::stat_t                     stat,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output bpdc_pkg::out_t                      out_data
);

	logic [bpdc_pkg::TICK_W-1:0]     long_q;
	logic [bpdc_pkg::TICK_W-1:0]     cont_q;
	logic [bpdc_pkg::TICK_W-1:0]     now_q;
	logic [bpdc_pkg::MASK_W-1:0]     clicked_q;
	logic [bpdc_pkg::MASK_W-1:0]     level_q;
	logic [bpdc_pkg::SCAN_COUNT-1:0] pressed_q;
	logic [bpdc_pkg::TICK_W-1:0]     start_q [bpdc_pkg::SCAN_COUNT];
	logic [bpdc_pkg::IDX_W-1:0]      idx_q;
	logic                            want_short_q;
	logic                            want_repeat_q;
	logic                            out_valid_q;
	bpdc_pkg::out_t                  out_q;

	logic                        btn_clk;
	logic                        btn_pf;
	logic                        btn_lv;
	logic [bpdc_pkg::TICK_W-1:0] dur;
	logic                        over_long;
	logic                        over_cont;
	logic                        ev_fire;
	logic [1:0]                  ev_kind;

	assign btn_clk   = clicked_q[idx_q];
	assign btn_pf    = pressed_q[idx_q];
	assign btn_lv    = level_q[idx_q];
	assign dur       = now_q - start_q[idx_q];
	assign over_long = (dur > long_q);
	assign over_cont = (dur > cont_q);
	assign ev_fire   = !btn_clk && btn_pf && (!btn_lv || over_cont);

	always_comb begin
		if (btn_lv)
			ev_kind = bpdc_pkg::EV_CONTINUOUS;
		else if (!over_long)
			ev_kind = bpdc_pkg::EV_SHORT;
		else if (over_cont)
			ev_kind = bpdc_pkg::EV_AFTER_CONT;
		else
			ev_kind = bpdc_pkg::EV_LONG;
	end

	assign stat.slot_free = !out_valid_q || out_ready;
	assign stat.last_btn  = (idx_q == bpdc_pkg::IDX_W'(bpdc_pkg::SCAN_COUNT - 1));
	assign out_valid      = out_valid_q;
	assign out_data       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q <= bpdc_pkg::LONG_PRESS_RESET;
			cont_q <= bpdc_pkg::CONT_PRESS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bpdc_pkg::CFG_LONG_PRESS: long_q <= cfg_wdata;
				bpdc_pkg::CFG_CONT_PRESS: cont_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q     <= in_data.now_tick;
			clicked_q <= in_data.clicked_mask;
			level_q   <= in_data.level_mask;
		end
		if (cmd.step && btn_clk && !btn_pf)
			start_q[idx_q] <= now_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q     <= '0;
			idx_q         <= '0;
			want_short_q  <= 1'b0;
			want_repeat_q <= 1'b0;
		end else if (cmd.load) begin
			idx_q         <= '0;
			want_short_q  <= 1'b0;
			want_repeat_q <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= bpdc_pkg::IDX_W'(idx_q + 1'b1);
			if (btn_clk) begin
				pressed_q[idx_q] <= 1'b1;
				want_short_q     <= 1'b1;
			end else if (btn_pf) begin
				if (!btn_lv)
					pressed_q[idx_q] <= 1'b0;
				else if (over_cont)
					want_repeat_q <= 1'b1;
				else
					want_short_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if ((cmd.step && ev_fire) || cmd.emit_status)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.step && ev_fire) begin
			out_q.is_status      <= 1'b0;
			out_q.button_index   <= 2'(idx_q);
			out_q.event_kind     <= ev_kind;
			out_q.recheck_short  <= 1'b0;
			out_q.recheck_repeat <= 1'b0;
			out_q.go_idle        <= 1'b0;
			out_q.last           <= 1'b0;
		end else if (cmd.emit_status) begin
			out_q.is_status      <= 1'b1;
			out_q.button_index   <= 2'd0;
			out_q.event_kind     <= bpdc_pkg::EV_SHORT;
			out_q.recheck_short  <= want_short_q;
			out_q.recheck_repeat <= want_repeat_q;
			out_q.go_idle        <= !(want_short_q || want_repeat_q);
			out_q.last           <= 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_step_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.emit_status) |-> (!out_valid_q || out_ready))
		else $error("step issued while output slot occupied");

	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_status |=> (out_valid_q && out_q.is_status && out_q.last))
		else $error("status beat not loaded");

	a_event_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && ev_fire) |=> (out_valid_q && !out_q.is_status && !out_q.last))
		else $error("event beat not loaded");

	a_idle_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_status) |->
		(out_q.go_idle == !(out_q.recheck_short || out_q.recheck_repeat)))
		else $error("go_idle inconsistent with recheck flags");
`endif

endmodule
`default_nettype wire

@@ src/button_press_duration_classifier.sv @@
// Top level of the button press duration classifier.
// Joins the controller and the datapath. Depends on bpdc_pkg, bpdc_ctrl and bpdc_dp.
`timescale 1ns / 1ps
`default_nettype none
// One input beat is one scan of the buttons. The block returns one event beat for
// each button released or held past the continuous limit, in button order, and then
// one status beat with last set. A scan loads the beat, steps each button through
// the single duration subtract and compare, then loads the status beat; a step or
// the status beat waits while the output register holds a beat not yet taken. A new scan is
// accepted as soon as the status beat sits in the output register. Registers:
// index 0 long press limit, index 1 continuous press limit; write them only while idle.
module button_press_duration_classifier (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [bpdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bpdc_pkg::TICK_W-1:0]    cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire bpdc_pkg::in_t                  in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output bpdc_pkg::out_t                      out_data
);

	bpdc_pkg::cmd_t  cmd;
	bpdc_pkg::stat_t stat;

	bpdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bpdc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
